// ----- sv/fba_pkg.sv -----
// ----------------------------------------------------------------------------
// fba_pkg
// Shared types, sizes and codes of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

	localparam int BITMAP_BYTES = 128;
	localparam int FRAME_COUNT  = BITMAP_BYTES * 8;
	localparam int INDEX_LIMIT  = 1024;
	localparam int FRAME_W      = 10;
	localparam int FUNC_W       = 2;
	localparam int STATUS_W     = 2;

	// bitmap is held as 32-bit words
	localparam int WORD_W       = 32;
	localparam int BIT_W        = 5;
	localparam int SEARCH_LIMIT = (FRAME_COUNT < INDEX_LIMIT) ? FRAME_COUNT : INDEX_LIMIT;
	localparam int SEARCH_WORDS = (SEARCH_LIMIT + WORD_W - 1) / WORD_W;
	localparam int ADDR_W       = (SEARCH_WORDS > 1) ? $clog2(SEARCH_WORDS) : 1;
	localparam int LAST_WORD    = SEARCH_WORDS - 1;
	localparam int TAIL_BITS    = SEARCH_LIMIT - LAST_WORD * WORD_W;

	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = 1;
	localparam int QCNT_W       = 2;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_ALLOC,
		CMD_CLEAR,
		CMD_SET,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [FRAME_W-1:0]  frame;
		logic [ADDR_W-1:0]   addr;
		logic [BIT_W-1:0]    bit_sel;
	} cmd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RMW,
		B_SCAN,
		B_FOUND
	} back_state_t;

	// bits past the last searchable frame count as used
	function automatic logic [WORD_W-1:0] tail_mask(input logic [ADDR_W-1:0] addr);
		logic [WORD_W-1:0] m;
		m = '0;
		if (addr == ADDR_W'(LAST_WORD)) begin
			for (int i = 0; i < WORD_W; i++) begin
				m[i] = (i >= TAIL_BITS);
			end
		end
		return m;
	endfunction

endpackage

// ----- sv/fba_if.sv -----
// ----------------------------------------------------------------------------
// fba_req_if / fba_res_if
// Valid-ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface fba_req_if;
	logic                         valid;
	logic                         ready;
	logic [fba_pkg::FUNC_W-1:0]   func;
	logic [fba_pkg::FRAME_W-1:0]  frame_index;

	modport source (output valid, output func, output frame_index, input ready);
	modport sink   (input valid, input func, input frame_index, output ready);
endinterface

interface fba_res_if;
	logic                          valid;
	logic                          ready;
	logic [fba_pkg::FRAME_W-1:0]   frame_index_res;
	logic [fba_pkg::STATUS_W-1:0]  status;

	modport source (output valid, output frame_index_res, output status, input ready);
	modport sink   (input valid, input frame_index_res, input status, output ready);
endinterface

// ----- sv/fba_front.sv -----
// ----------------------------------------------------------------------------
// fba_front
// Takes request beats and sorts them into commands for the back end.
// ----------------------------------------------------------------------------
module fba_front (
	fba_req_if.sink         req,
	input  logic            q_full,
	output logic            push,
	output fba_pkg::cmd_t   cmd
);

	logic in_range;

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;
	assign in_range  = 32'(req.frame_index) < fba_pkg::FRAME_COUNT;

	always_comb begin
		cmd.frame   = req.frame_index;
		cmd.addr    = fba_pkg::ADDR_W'(req.frame_index >> fba_pkg::BIT_W);
		cmd.bit_sel = req.frame_index[fba_pkg::BIT_W-1:0];
		case (req.func)
			fba_pkg::FUNC_ALLOC: cmd.kind = fba_pkg::CMD_ALLOC;
			fba_pkg::FUNC_FREE:  cmd.kind = in_range ? fba_pkg::CMD_CLEAR : fba_pkg::CMD_REJECT;
			fba_pkg::FUNC_MARK:  cmd.kind = in_range ? fba_pkg::CMD_SET : fba_pkg::CMD_REJECT;
			default:             cmd.kind = fba_pkg::CMD_REJECT;
		endcase
	end

endmodule

// ----- sv/fba_queue.sv -----
// ----------------------------------------------------------------------------
// fba_queue
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module fba_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  fba_pkg::cmd_t   cmd_in,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output fba_pkg::cmd_t   cmd_out
);

	fba_pkg::cmd_t                    slot_q [fba_pkg::QUEUE_DEPTH];
	logic [fba_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [fba_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [fba_pkg::QCNT_W-1:0]       count_q;

	assign full    = count_q == fba_pkg::QCNT_W'(fba_pkg::QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign cmd_out = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= cmd_in;
	end

endmodule

// ----- sv/fba_back.sv -----
// ----------------------------------------------------------------------------
// fba_back
// Executes commands against the word-wide bitmap memory and drives results.
// ----------------------------------------------------------------------------
module fba_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  fba_pkg::cmd_t   q_cmd,
	output logic            pop,
	fba_res_if.source       res
);

	localparam int WW = fba_pkg::WORD_W;
	localparam int AW = fba_pkg::ADDR_W;

	logic [WW-1:0]                 mem [fba_pkg::SEARCH_WORDS];
	logic [fba_pkg::SEARCH_WORDS-1:0] word_vld_q;
	logic [WW-1:0]                 rdata_q;
	logic                          rvld_q;

	fba_pkg::back_state_t          state_q, state_d;
	fba_pkg::cmd_t                 cmd_q;
	logic [AW-1:0]                 scan_addr_q;
	logic [AW-1:0]                 chk_addr_q;
	logic [WW-1:0]                 found_word_q;
	logic [AW-1:0]                 found_addr_q;

	logic                          out_vld_q;
	logic [fba_pkg::FRAME_W-1:0]   out_frame_q;
	logic [fba_pkg::STATUS_W-1:0]  out_status_q;

	logic                          start;
	logic                          rd_en, we, out_load;
	logic [AW-1:0]                 rd_addr, wr_addr;
	logic [WW-1:0]                 wr_data;
	logic [fba_pkg::FRAME_W-1:0]   out_frame_d;
	fba_pkg::status_t              out_status_d;

	logic [WW-1:0]                 word_now, scan_word, rmw_word, bit_onehot;
	logic                          scan_hit, scan_last;
	logic [fba_pkg::BIT_W-1:0]     found_bit;

	// word never written since reset reads as all free
	assign word_now   = rvld_q ? rdata_q : '0;
	assign scan_word  = word_now | fba_pkg::tail_mask(chk_addr_q);
	assign scan_hit   = scan_word != '1;
	assign scan_last  = chk_addr_q == AW'(fba_pkg::LAST_WORD);
	assign bit_onehot = WW'(1) << cmd_q.bit_sel;
	assign rmw_word   = (cmd_q.kind == fba_pkg::CMD_SET) ? (word_now | bit_onehot)
	                                                     : (word_now & ~bit_onehot);
	assign start      = (state_q == fba_pkg::B_IDLE) && !q_empty && !out_vld_q;

	// lowest clear bit of the hit word
	always_comb begin
		found_bit = '0;
		for (int i = WW - 1; i >= 0; i--) begin
			if (!found_word_q[i]) found_bit = fba_pkg::BIT_W'(i);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fba_pkg::B_IDLE: begin
				if (start) begin
					case (q_cmd.kind)
						fba_pkg::CMD_ALLOC: state_d = fba_pkg::B_SCAN;
						fba_pkg::CMD_CLEAR,
						fba_pkg::CMD_SET:   state_d = fba_pkg::B_RMW;
						default:            state_d = fba_pkg::B_IDLE;
					endcase
				end
			end
			fba_pkg::B_RMW:   state_d = fba_pkg::B_IDLE;
			fba_pkg::B_SCAN: begin
				if (scan_hit)       state_d = fba_pkg::B_FOUND;
				else if (scan_last) state_d = fba_pkg::B_IDLE;
			end
			fba_pkg::B_FOUND: state_d = fba_pkg::B_IDLE;
			default:          state_d = fba_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop          = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = '0;
		we           = 1'b0;
		wr_addr      = cmd_q.addr;
		wr_data      = rmw_word;
		out_load     = 1'b0;
		out_frame_d  = cmd_q.frame;
		out_status_d = fba_pkg::ST_OK;
		case (state_q)
			fba_pkg::B_IDLE: begin
				if (start) begin
					pop = 1'b1;
					case (q_cmd.kind)
						fba_pkg::CMD_ALLOC: begin
							rd_en   = 1'b1;
							rd_addr = '0;
						end
						fba_pkg::CMD_CLEAR,
						fba_pkg::CMD_SET: begin
							rd_en   = 1'b1;
							rd_addr = q_cmd.addr;
						end
						default: begin
							out_load     = 1'b1;
							out_frame_d  = q_cmd.frame;
							out_status_d = fba_pkg::ST_RANGE;
						end
					endcase
				end
			end
			fba_pkg::B_RMW: begin
				we       = 1'b1;
				out_load = 1'b1;
			end
			fba_pkg::B_SCAN: begin
				if (!scan_hit) begin
					if (scan_last) begin
						out_load     = 1'b1;
						out_frame_d  = '0;
						out_status_d = fba_pkg::ST_FULL;
					end else begin
						rd_en   = 1'b1;
						rd_addr = scan_addr_q;
					end
				end
			end
			fba_pkg::B_FOUND: begin
				we          = 1'b1;
				wr_addr     = found_addr_q;
				wr_data     = found_word_q | (WW'(1) << found_bit);
				out_load    = 1'b1;
				out_frame_d = fba_pkg::FRAME_W'({found_addr_q, found_bit});
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fba_pkg::B_IDLE;
			out_vld_q  <= 1'b0;
			word_vld_q <= '0;
			rvld_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load)       out_vld_q <= 1'b1;
			else if (res.ready) out_vld_q <= 1'b0;
			if (we)    word_vld_q[wr_addr] <= 1'b1;
			if (rd_en) rvld_q <= word_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we)    mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q       <= q_cmd;
			chk_addr_q  <= '0;
			scan_addr_q <= AW'(1);
		end else if (state_q == fba_pkg::B_SCAN && !scan_hit) begin
			chk_addr_q  <= scan_addr_q;
			scan_addr_q <= scan_addr_q + 1'b1;
		end
		if (state_q == fba_pkg::B_SCAN && scan_hit) begin
			found_word_q <= scan_word;
			found_addr_q <= chk_addr_q;
		end
		if (out_load) begin
			out_frame_q  <= out_frame_d;
			out_status_q <= out_status_d;
		end
	end

	assign res.valid           = out_vld_q;
	assign res.frame_index_res = out_frame_q;
	assign res.status          = out_status_q;

	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !out_vld_q)
		else $error("command popped while a result is pending");

	a_found_has_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fba_pkg::B_FOUND) |-> (found_word_q != '1))
		else $error("found word has no free bit");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == fba_pkg::B_RMW || state_q == fba_pkg::B_FOUND))
		else $error("bitmap written outside an update step");

	a_alloc_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fba_pkg::B_FOUND) |=>
		(out_vld_q && 32'(out_frame_q) < fba_pkg::SEARCH_LIMIT))
		else $error("allocated frame beyond search limit");

endmodule

// ----- sv/frame_bitmap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_top
// First-fit page frame allocator over a one-bit-per-frame used bitmap.
// ----------------------------------------------------------------------------
// out of range or bad op: the request passes the queue and loads the result register;
// free and mark: read-modify-write of one word on the single-port bitmap memory
// allocate: reads word 0, scans one 32-bit word per cycle, then writes the hit
// word; one request in flight, the next starts after its result is taken
// a two-entry queue keeps taking request beats, until full, while a result waits
// reset: per-word valid flags clear at once, so every frame is free, no sweep
module frame_bitmap_allocator_top (
	input  logic       clk,
	input  logic       arst_n,
	fba_req_if.sink    req,
	fba_res_if.source  res
);

	logic            q_full, q_empty, push, pop;
	fba_pkg::cmd_t   front_cmd, head_cmd;

	fba_front u_front (
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.cmd    (front_cmd)
	);

	fba_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (front_cmd),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.cmd_out (head_cmd)
	);

	fba_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_cmd   (head_cmd),
		.pop     (pop),
		.res     (res)
	);

endmodule
